>>> rtl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

    // Default parameter values.
    localparam int DEF_SAMPLE_WIDTH      = 16;
    localparam int DEF_GAIN_FRACTION     = 8;

    // Fixed widths of the datapath.
    localparam int GAIN_W      = 16;
    localparam int ERR_W       = 17;
    localparam int INTEG_W     = 32;
    localparam int DRIVE_W     = 16;
    localparam int OUT_LIM_W   = 15;
    localparam int ERR_LIM_W   = 16;
    localparam int INT_LIM_W   = 31;
    localparam int DEAD_W      = 16;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORM_SELECT    = 3'd7;

    localparam logic FORM_POSITIONAL  = 1'b0;
    localparam logic FORM_INCREMENTAL = 1'b1;

    // Error queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [OUT_LIM_W-1:0]     output_limit;
        logic [ERR_LIM_W-1:0]     error_limit;
        logic [INT_LIM_W-1:0]     integral_limit;
        logic [DEAD_W-1:0]        deadband;
        logic                     form_select;
    } t_cfg;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } t_q_status;

endpackage

`default_nettype wire

>>> rtl/pidc_if.sv
`default_nettype none

// Sample request channel: target and measured value.
interface pidc_in_if #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] actual;

    modport source (output valid, output target, output actual, input ready);
    modport sink   (input valid, input target, input actual, output ready);
endinterface

// Drive result channel.
interface pidc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pidc_pkg::DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// Register write channel.
interface pidc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pidc_pkg::CFG_IDX_W-1:0]     index;
    logic [pidc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pidc_front.sv
`default_nettype none

module pidc_front #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pidc_pkg::t_cfg                     i_cfg,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_target,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_actual,
    input  wire logic                               i_q_full,
    output logic                                    o_push,
    output logic signed [pidc_pkg::ERR_W-1:0]       o_err
);

    localparam int ERR_W  = pidc_pkg::ERR_W;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > ERR_W + 1) ? DIFF_W : ERR_W + 1;

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_err;
    logic signed [CMP_W-1:0] diff;
    logic signed [CMP_W-1:0] lim;
    logic signed [CMP_W-1:0] clamped;
    logic signed [ERR_W-1:0] err_c;
    logic [ERR_W-1:0]        mag;
    logic signed [ERR_W-1:0] n_err;
    logic                    accept;

    // Error, clamped to the error bound and forced to zero inside the dead zone.
    always_comb begin
        diff = CMP_W'(i_target) - CMP_W'(i_actual);
        lim  = CMP_W'(signed'({1'b0, i_cfg.error_limit}));
        if (diff > lim) begin
            clamped = lim;
        end else if (diff < -lim) begin
            clamped = -lim;
        end else begin
            clamped = diff;
        end
        err_c = ERR_W'(clamped);
        mag   = err_c[ERR_W-1] ? ERR_W'(-err_c) : err_c;
        if (mag <= {1'b0, i_cfg.deadband}) begin
            n_err = '0;
        end else begin
            n_err = err_c;
        end
    end

    // The holding register frees up whenever the queue takes its entry.
    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_err   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidc_queue.sv
`default_nettype none

module pidc_queue (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    input  wire logic signed [pidc_pkg::ERR_W-1:0]  i_data,
    input  wire logic                               i_pop,
    output logic signed [pidc_pkg::ERR_W-1:0]       o_data,
    output pidc_pkg::t_q_status                     o_status
);

    localparam int DEPTH = pidc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = pidc_pkg::QUEUE_CNT_W;

    logic signed [pidc_pkg::ERR_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]                  r_wr_ptr;
    logic [PTR_W-1:0]                  r_rd_ptr;
    logic [CNT_W-1:0]                  r_count;
    logic                              full;
    logic                              empty;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_data          = r_entry[r_rd_ptr];
    assign o_status.count  = r_count;
    assign o_status.full   = full;
    assign o_status.empty  = empty;

    // Pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pidc_back.sv
`default_nettype none

module pidc_back #(
    parameter int GAIN_FRACTION_BITS = pidc_pkg::DEF_GAIN_FRACTION
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pidc_pkg::t_cfg                     i_cfg,
    input  wire logic                               i_q_valid,
    input  wire logic signed [pidc_pkg::ERR_W-1:0]  i_err,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]     o_drive
);

    localparam int ERR_W   = pidc_pkg::ERR_W;
    localparam int GAIN_W  = pidc_pkg::GAIN_W;
    localparam int INTEG_W = pidc_pkg::INTEG_W;
    localparam int DRIVE_W = pidc_pkg::DRIVE_W;
    localparam int ACC_W   = INTEG_W + 1;
    localparam int D1_W    = ERR_W + 1;
    localparam int D2_W    = ERR_W + 3;
    localparam int OPP_W   = D1_W;
    localparam int OPI_W   = INTEG_W;
    localparam int OPD_W   = D2_W;
    localparam int PP_W    = GAIN_W + OPP_W;
    localparam int PI_W    = GAIN_W + OPI_W;
    localparam int PD_W    = GAIN_W + OPD_W;
    localparam int SUM_W   = PI_W + 2;
    localparam int OUT_W   = SUM_W + 1;

    // Error history and integral.
    logic signed [ERR_W-1:0]   r_prev;
    logic signed [ERR_W-1:0]   r_before_prev;
    logic signed [INTEG_W-1:0] r_integral;

    // Pipeline registers.
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_out_valid;
    logic signed [OPP_W-1:0]   r_op_p;
    logic signed [OPI_W-1:0]   r_op_i;
    logic signed [OPD_W-1:0]   r_op_d;
    logic signed [PP_W-1:0]    r_prod_p;
    logic signed [PI_W-1:0]    r_prod_i;
    logic signed [PD_W-1:0]    r_prod_d;
    logic signed [SUM_W-1:0]   r_scaled;
    logic signed [DRIVE_W-1:0] r_held;

    logic                      adv;
    logic                      positional;
    logic signed [ACC_W-1:0]   acc_raw;
    logic signed [ACC_W-1:0]   acc_lim;
    logic signed [ACC_W-1:0]   acc_clr;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [INTEG_W-1:0] n_integral;
    logic signed [D1_W-1:0]    diff1;
    logic signed [D2_W-1:0]    diff2;
    logic signed [OPP_W-1:0]   n_op_p;
    logic signed [OPI_W-1:0]   n_op_i;
    logic signed [OPD_W-1:0]   n_op_d;
    logic signed [SUM_W-1:0]   sum;
    logic signed [OUT_W-1:0]   pre_sat;
    logic signed [OUT_W-1:0]   out_lim;
    logic signed [DRIVE_W-1:0] n_held;

    // The whole back pipeline moves when the output slot is free.
    assign adv        = !r_out_valid || i_ready;
    assign o_pop      = adv && i_q_valid;
    assign positional = (i_cfg.form_select == pidc_pkg::FORM_POSITIONAL);
    assign o_valid    = r_out_valid;
    assign o_drive    = r_held;

    // Integral with sign reset and clamp; differences of the error history.
    always_comb begin
        acc_raw = ACC_W'(r_integral) + ACC_W'(i_err);
        acc_lim = ACC_W'(signed'({2'b00, i_cfg.integral_limit}));
        if ((i_err < 0 && acc_raw > 0) || (i_err > 0 && acc_raw < 0)) begin
            acc_clr = '0;
        end else begin
            acc_clr = acc_raw;
        end
        if (acc_clr > acc_lim) begin
            acc_sat = acc_lim;
        end else if (acc_clr < -acc_lim) begin
            acc_sat = -acc_lim;
        end else begin
            acc_sat = acc_clr;
        end
        n_integral = INTEG_W'(acc_sat);
        diff1 = D1_W'(i_err) - D1_W'(r_prev);
        diff2 = D2_W'(i_err) - D2_W'(r_prev) - D2_W'(r_prev) + D2_W'(r_before_prev);
        if (positional) begin
            n_op_p = OPP_W'(i_err);
            n_op_i = n_integral;
            n_op_d = OPD_W'(diff1);
        end else begin
            n_op_p = diff1;
            n_op_i = OPI_W'(i_err);
            n_op_d = diff2;
        end
    end

    // State of the loop advances once per popped error.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_before_prev <= '0;
            r_integral    <= '0;
        end else if (o_pop) begin
            r_prev <= i_err;
            if (positional) begin
                r_integral <= n_integral;
            end else begin
                r_before_prev <= r_prev;
            end
        end
    end

    // Sum of products, later scaled by the gain fraction with floor rounding.
    always_comb begin
        sum = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
    end

    // Output saturation; the incremental form builds on the held drive.
    always_comb begin
        if (positional) begin
            pre_sat = OUT_W'(r_scaled);
        end else begin
            pre_sat = OUT_W'(r_held) + OUT_W'(r_scaled);
        end
        out_lim = OUT_W'(signed'({1'b0, i_cfg.output_limit}));
        if (pre_sat > out_lim) begin
            n_held = DRIVE_W'(out_lim);
        end else if (pre_sat < -out_lim) begin
            n_held = DRIVE_W'(-out_lim);
        end else begin
            n_held = DRIVE_W'(pre_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= i_q_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op_p   <= n_op_p;
            r_op_i   <= n_op_i;
            r_op_d   <= n_op_d;
            r_prod_p <= i_cfg.gain_p * r_op_p;
            r_prod_i <= i_cfg.gain_i * r_op_i;
            r_prod_d <= i_cfg.gain_d * r_op_d;
            r_scaled <= sum >>> GAIN_FRACTION_BITS;
        end
    end

    // The held drive is the last result loaded into the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (adv && r_v3) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pid_controller_dual_form_core.sv
`default_nettype none

// PID controller, positional or incremental form, in fixed point. Each request
// carries a target and a measured sample and yields one saturated drive value.
// Gains are signed with GAIN_FRACTION_BITS fraction bits; sums of products are
// shifted right with floor rounding. Unless the output stalls, the block takes
// one request per clock: the error history and integral are closed within the
// first back stage and the held drive within the output stage, so no request
// waits on another. A request passes the front holding register, the queue and
// the operand, product, scaled and output registers. A two-entry error queue
// sits between the front (error clamp and dead zone) and the back (multiply,
// sum, saturate). Registers are written through the configuration channel,
// which is always ready; write them only while no request is in flight.
module pid_controller_dual_form_core #(
    parameter int SAMPLE_WIDTH       = pidc_pkg::DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRACTION_BITS = pidc_pkg::DEF_GAIN_FRACTION
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pidc_in_if.sink     i_in,
    pidc_out_if.source  o_out,
    pidc_cfg_if.sink    i_cfg
);

    pidc_pkg::t_cfg                      r_cfg;
    pidc_pkg::t_q_status                 q_status;
    logic                                front_push;
    logic signed [pidc_pkg::ERR_W-1:0]   front_err;
    logic signed [pidc_pkg::ERR_W-1:0]   q_err;
    logic                                back_pop;
    logic                                cfg_write;

    // Register file.
    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.output_limit   <= '1;
            r_cfg.error_limit    <= '1;
            r_cfg.integral_limit <= '1;
            r_cfg.deadband       <= '0;
            r_cfg.form_select    <= pidc_pkg::FORM_POSITIONAL;
        end else if (cfg_write) begin
            unique case (i_cfg.index)
                pidc_pkg::REG_GAIN_P: begin
                    r_cfg.gain_p <= signed'(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                end
                pidc_pkg::REG_GAIN_I: begin
                    r_cfg.gain_i <= signed'(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                end
                pidc_pkg::REG_GAIN_D: begin
                    r_cfg.gain_d <= signed'(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                end
                pidc_pkg::REG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg.data[pidc_pkg::OUT_LIM_W-1:0];
                end
                pidc_pkg::REG_ERROR_LIMIT: begin
                    r_cfg.error_limit <= i_cfg.data[pidc_pkg::ERR_LIM_W-1:0];
                end
                pidc_pkg::REG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg.data[pidc_pkg::INT_LIM_W-1:0];
                end
                pidc_pkg::REG_DEADBAND: begin
                    r_cfg.deadband <= i_cfg.data[pidc_pkg::DEAD_W-1:0];
                end
                pidc_pkg::REG_FORM_SELECT: begin
                    r_cfg.form_select <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front: error formation.
    pidc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_target (i_in.target),
        .i_actual (i_in.actual),
        .i_q_full (q_status.full),
        .o_push   (front_push),
        .o_err    (front_err)
    );

    // Error queue.
    pidc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_data   (front_err),
        .i_pop    (back_pop),
        .o_data   (q_err),
        .o_status (q_status)
    );

    // Back: control law and saturation.
    pidc_back #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (!q_status.empty),
        .i_err     (q_err),
        .o_pop     (back_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_drive   (o_out.drive)
    );

    // The queue count stays in range and agrees with its flags.
    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.count <= pidc_pkg::QUEUE_CNT_W'(pidc_pkg::QUEUE_DEPTH))
        && (q_status.full != q_status.empty || q_status.count != '0))
        else $error("queue count out of range");

    // The front only refuses a request while the queue is full.
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_status.full)
        else $error("front stalled with room in the queue");

    // A pop from the queue happens only when the queue holds an entry.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // Saturation never lets the most negative code through.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.drive != {1'b1, {(pidc_pkg::DRIVE_W-1){1'b0}}})
        else $error("drive outside the symmetric range");

endmodule

`default_nettype wire
